// File: hw/rtl/cursor_text_buffer_core_macros.svh
// Assertion helpers for the cursor text buffer datapath (ctb_dp).
`ifndef CURSOR_TEXT_BUFFER_CORE_MACROS_SVH
`define CURSOR_TEXT_BUFFER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge.
`define CTB_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cursor text buffer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CTB_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cursor text buffer check failed");

`else

`define CTB_ASSERT_IMP(name, clk, rst, pre, post)
`define CTB_ASSERT_NXT(name, clk, rst, pre, post)

`endif

`endif

// File: hw/rtl/ctb_pkg.sv
package ctb_pkg;

  localparam int DEF_CAPACITY = 1024;

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 10;
  localparam int TLEN_W = 11;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  read_position;
  } ctb_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [TLEN_W-1:0] text_length;
    logic [TLEN_W-1:0] cursor_position;
    logic [STAT_W-1:0] status;
  } ctb_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctb_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } ctb_sts_t;

endpackage

// File: hw/rtl/ctb_ram.sv
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ctb_ctrl.sv
module ctb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  ctb_pkg::ctb_sts_t sts,
  output ctb_pkg::ctb_ctl_t ctl
);
  import ctb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WRITE
  } state_t;

  state_t state;

  assign request_stall = (state != S_IDLE);
  assign ctl.capture   = (state == S_IDLE) && request_valid;
  assign ctl.commit    = (state == S_WRITE) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.capture) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          // hold until the result register can take the result
          if (ctl.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/ctb_dp.sv
`include "cursor_text_buffer_core_macros.svh"

module ctb_dp #(
  parameter int CAPACITY = ctb_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  ctb_pkg::ctb_req_t request,
  input  ctb_pkg::ctb_ctl_t ctl,
  output ctb_pkg::ctb_sts_t sts,
  output logic              result_valid,
  input  logic              result_stall,
  output ctb_pkg::ctb_rsp_t result
);
  import ctb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [CW-1:0]     left_count;
  logic [CW-1:0]     right_count;
  logic [CW-1:0]     left_count_next;
  logic [CW-1:0]     right_count_next;
  ctb_req_t          req;
  logic [CW-1:0]     sum;
  logic [EW-1:0]     left_e;
  logic [EW-1:0]     right_e;
  logic [EW-1:0]     sum_e;
  logic [EW-1:0]     in_pos_e;
  logic [EW-1:0]     in_phys_e;
  logic [EW-1:0]     req_pos_e;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic              wr_req;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [CHAR_W-1:0] char_next;
  logic [STAT_W-1:0] status_next;

  assign sum       = left_count + right_count;
  assign left_e    = EW'(left_count);
  assign right_e   = EW'(right_count);
  assign sum_e     = EW'(sum);
  assign in_pos_e  = EW'(request.read_position);
  assign in_phys_e = CAP_E - right_e + in_pos_e - left_e;
  assign req_pos_e = EW'(req.read_position);

  // Read address for the request on the input port, issued in its accept cycle.
  always_comb begin
    case (request.command)
      CMD_LEFT:  rd_addr = AW'(left_count - ONE_C);
      CMD_RIGHT: rd_addr = AW'(CAP_C - right_count);
      default:   rd_addr = (in_pos_e < left_e) ? AW'(in_pos_e) : AW'(in_phys_e);
    endcase
  end

  // Write-back and result for the held request.
  always_comb begin
    left_count_next  = left_count;
    right_count_next = right_count;
    wr_req           = 1'b0;
    wr_addr          = AW'(left_count);
    wr_data          = rd_data;
    char_next        = '0;
    status_next      = ST_DONE;
    case (req.command)
      CMD_LEFT: begin
        if (left_count == '0) begin
          status_next = ST_IGNORED;
        end else begin
          wr_req           = 1'b1;
          wr_addr          = AW'(CAP_C - right_count - ONE_C);
          left_count_next  = left_count - ONE_C;
          right_count_next = right_count + ONE_C;
        end
      end
      CMD_RIGHT: begin
        if (right_count == '0) begin
          status_next = ST_IGNORED;
        end else begin
          wr_req           = 1'b1;
          left_count_next  = left_count + ONE_C;
          right_count_next = right_count - ONE_C;
        end
      end
      CMD_INSERT: begin
        if (sum >= CAP_C) begin
          status_next = ST_FULL;
        end else begin
          wr_req          = 1'b1;
          wr_data         = req.char_in;
          left_count_next = left_count + ONE_C;
        end
      end
      CMD_DELETE: begin
        if (left_count == '0) begin
          status_next = ST_IGNORED;
        end else begin
          left_count_next = left_count - ONE_C;
        end
      end
      CMD_READ: begin
        if (req_pos_e < sum_e) begin
          char_next = rd_data;
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_IGNORED;
      end
    endcase
  end

  ctb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (ctl.commit && wr_req),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (ctl.capture),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign sts.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req <= request;
    end
    if (ctl.commit) begin
      result.char_out        <= char_next;
      result.text_length     <= TLEN_W'(left_count_next + right_count_next);
      result.cursor_position <= TLEN_W'(left_count_next);
      result.status          <= status_next;
    end
    if (rst) begin
      left_count   <= '0;
      right_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        left_count   <= left_count_next;
        right_count  <= right_count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `CTB_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, sum <= CAP_C)
  `CTB_ASSERT_NXT(a_one_in_flight, clk, rst, ctl.capture, !ctl.capture)
  `CTB_ASSERT_NXT(a_counts_hold, clk, rst, !rst && !ctl.commit, $stable(left_count) && $stable(right_count))
  `CTB_ASSERT_IMP(a_no_overwrite, clk, rst, result_valid && result_stall, !ctl.commit)

endmodule

// File: hw/rtl/cursor_text_buffer_core.sv
// Channel   Direction  Handshake                        Payload
// request   in         request_valid / request_stall    request  (ctb_req_t)
// result    out        result_valid  / result_stall     result   (ctb_rsp_t)
//
// Each request is accepted in S_IDLE, which issues the one store read
// (registered read port); S_WRITE then writes back across the gap and loads
// the result register. Because of the registered read, the byte that
// crosses the gap only arrives in the cycle after the accept.
// A stalled result holds the write-back cycle until the result register frees.
// Reset (rst, synchronous) clears only the counts, result_valid and FSM state;
// the store needs no clearing pass since only written entries are ever read.
module cursor_text_buffer_core #(
  parameter int CAPACITY = ctb_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  ctb_pkg::ctb_req_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output ctb_pkg::ctb_rsp_t result
);
  import ctb_pkg::*;

  // Command and status between the sequencer and the gap-buffer datapath.
  ctb_ctl_t ctl;
  ctb_sts_t sts;

  // Sequence one request at a time: accept, then write back.
  ctb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .sts          (sts),
    .ctl          (ctl)
  );

  // Hold the counts, the text store and the result register.
  ctb_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .ctl         (ctl),
    .sts         (sts),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

// File: sim/cursor_text_buffer_core_tb.sv
`timescale 1ns / 100ps

module cursor_text_buffer_core_tb;
  import ctb_pkg::*;

  localparam int CAPACITY   = DEF_CAPACITY;
  localparam int IDLE_LIMIT = 5000;
  localparam int CMD_LAST   = (1 << CMD_W) - 1;

  // Stimulus mixes: a short free-for-all on a small text, a long stretch that
  // grows the text to capacity, then a stretch that mostly deletes.
  typedef enum {MIX_NOISE, MIX_FILL, MIX_DRAIN} mix_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_t;

  logic     clk           = 1'b0;
  logic     rst           = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  ctb_req_t request       = '0;
  logic     result_valid;
  logic     result_stall  = 1'b0;
  ctb_rsp_t result;

  // Requests waiting to be driven, and the buffer snapshots that accepted
  // requests will report, oldest first.
  ctb_req_t edit_queue[$];
  ctb_rsp_t snapshot_queue[$];

  // Shadow gap buffer: left text at the bottom, right text at the top.
  logic [CHAR_W-1:0] text_shadow [CAPACITY];
  int unsigned       left_len  = 0;
  int unsigned       right_len = 0;

  int mismatches  = 0;
  int idle_cycles = 0;

  cursor_text_buffer_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow buffer and return the snapshot it reports.
  function automatic ctb_rsp_t apply_edit(ctb_req_t req);
    ctb_rsp_t    snap;
    int unsigned pos;
    snap        = '0;
    snap.status = ST_DONE;
    pos         = req.read_position;
    case (req.command)
      CMD_LEFT: begin
        if (left_len == 0) begin
          snap.status = ST_IGNORED;
        end else begin
          // Carry the byte left of the cursor across the gap.
          text_shadow[CAPACITY - right_len - 1] = text_shadow[left_len - 1];
          left_len--;
          right_len++;
        end
      end
      CMD_RIGHT: begin
        if (right_len == 0) begin
          snap.status = ST_IGNORED;
        end else begin
          text_shadow[left_len] = text_shadow[CAPACITY - right_len];
          left_len++;
          right_len--;
        end
      end
      CMD_INSERT: begin
        if (left_len + right_len >= CAPACITY) begin
          snap.status = ST_FULL;
        end else begin
          text_shadow[left_len] = req.char_in;
          left_len++;
        end
      end
      CMD_DELETE: begin
        if (left_len == 0) snap.status = ST_IGNORED;
        else left_len--;
      end
      CMD_READ: begin
        // Logical positions past the cursor map into the top of the store.
        if (pos < left_len) begin
          snap.char_out = text_shadow[pos];
        end else if (pos < left_len + right_len) begin
          snap.char_out = text_shadow[CAPACITY - right_len + (pos - left_len)];
        end else begin
          snap.status = ST_RANGE;
        end
      end
      default: snap.status = ST_IGNORED;
    endcase
    snap.text_length     = TLEN_W'(left_len + right_len);
    snap.cursor_position = TLEN_W'(left_len);
    return snap;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_edit(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                           logic [POS_W-1:0] pos);
    ctb_req_t req;
    req.command       = cmd;
    req.char_in       = ch;
    req.read_position = pos;
    edit_queue.push_back(req);
  endtask

  // Queue one random request drawn from the given mix; hand back its command.
  task automatic add_random(input mix_t mix, output logic [CMD_W-1:0] cmd);
    int               roll;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_NOISE: cmd = CMD_W'($urandom_range(0, CMD_LAST));
      MIX_FILL: begin
        if (roll < 70)      cmd = CMD_INSERT;
        else if (roll < 80) cmd = CMD_LEFT;
        else if (roll < 90) cmd = CMD_RIGHT;
        else                cmd = CMD_READ;
      end
      default: begin
        if (roll < 40)      cmd = CMD_DELETE;
        else if (roll < 55) cmd = CMD_LEFT;
        else if (roll < 75) cmd = CMD_RIGHT;
        else if (roll < 90) cmd = CMD_READ;
        else if (roll < 98) cmd = CMD_INSERT;
        else                cmd = CMD_W'($urandom_range(CMD_READ + 1, CMD_LAST));
      end
    endcase
    // Keep reads near the text while it is still short.
    if (mix == MIX_NOISE && $urandom_range(0, 1) == 1) pos = POS_W'($urandom_range(0, 15));
    else pos = POS_W'($urandom);
    push_edit(cmd, CHAR_W'($urandom), pos);
  endtask

  // Stimulus, then the end of the run.
  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    int               inserts;

    // Empty buffer: every boundary case answers ignored or out of range.
    push_edit(CMD_LEFT,   CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_RIGHT,  CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_DELETE, CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_READ,   CHAR_W'($urandom), '0);
    push_edit(CMD_READ,   CHAR_W'($urandom), '1);
    for (int c = CMD_READ + 1; c <= CMD_LAST; c++)
      push_edit(CMD_W'(c), CHAR_W'($urandom), POS_W'($urandom));
    // Build a three-byte text with the extreme byte values.
    push_edit(CMD_INSERT, 8'h00, POS_W'($urandom));
    push_edit(CMD_INSERT, 8'hFF, POS_W'($urandom));
    push_edit(CMD_INSERT, 8'h5A, POS_W'($urandom));
    push_edit(CMD_READ,   CHAR_W'($urandom), 10'd0);
    push_edit(CMD_READ,   CHAR_W'($urandom), 10'd2);
    push_edit(CMD_READ,   CHAR_W'($urandom), 10'd3);
    // Move the cursor back so reads hit the right-hand side of the gap.
    push_edit(CMD_LEFT,   CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_LEFT,   CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_READ,   CHAR_W'($urandom), 10'd1);
    push_edit(CMD_READ,   CHAR_W'($urandom), 10'd2);
    push_edit(CMD_DELETE, CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_DELETE, CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_RIGHT,  CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_RIGHT,  CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_RIGHT,  CHAR_W'($urandom), POS_W'($urandom));
    push_edit(CMD_READ,   CHAR_W'($urandom), 10'd1);
    push_edit(CMD_READ,   CHAR_W'($urandom), '1);

    repeat (150) add_random(MIX_NOISE, cmd);

    // No deletes while filling, so this many inserts is sure to reach full
    // and then knock on the full buffer at least two dozen times.
    inserts = 0;
    while (inserts < CAPACITY + 24) begin
      add_random(MIX_FILL, cmd);
      if (cmd == CMD_INSERT) inserts++;
    end

    repeat (230) add_random(MIX_DRAIN, cmd);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every snapshot to come back; look
    // between edges so the clocked blocks have settled.
    while (edit_queue.size() != 0 || request_valid || snapshot_queue.size() != 0)
      @(negedge clk);
    // Drain a few more cycles to catch any stray result.
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: send requests in bursts, mostly with idle gaps between them. Hold the
  // payload while stalled; on acceptance, predict the snapshot and advance.
  always @(posedge clk) begin : driver
    int burst_left;
    int gap_left;
    if (rst) begin
      request_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (request_valid && !request_stall)
        snapshot_queue.push_back(apply_edit(request));
      if (!request_valid || !request_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          request_valid <= 1'b0;
        end else if (edit_queue.size() != 0) begin
          request       <= edit_queue.pop_front();
          request_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // Close the burst; a quarter of the time run straight into the next.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          request_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest snapshot, and
  // stall the result channel in stretches of none, light and heavy stalling.
  always @(posedge clk) begin : monitor
    ctb_rsp_t want;
    stall_t   stall_mode;
    int       stall_run;
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode = STALL_NONE;
      stall_run  = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (snapshot_queue.size() == 0) begin
          $error("result accepted with no request outstanding");
          mismatches++;
        end else begin
          want = snapshot_queue.pop_front();
          check_field("char_out",        want.char_out,        result.char_out);
          check_field("text_length",     want.text_length,     result.text_length);
          check_field("cursor_position", want.cursor_position, result.cursor_position);
          check_field("status",          want.status,          result.status);
        end
      end
      if (stall_run == 0) begin
        stall_mode = stall_t'($urandom_range(0, 2));
        stall_run  = $urandom_range(8, 64);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        STALL_NONE:  result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        default:     result_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Watchdog: drop the run if nothing moves on either channel for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

// File: cursor_text_buffer_core.f
+incdir+hw/rtl
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_ram.sv
hw/rtl/ctb_ctrl.sv
hw/rtl/ctb_dp.sv
hw/rtl/cursor_text_buffer_core.sv
sim/cursor_text_buffer_core_tb.sv
